FILE: sv/dcrs_pkg.sv
// Shared types, codes and constants of the DMX channel ramp smoother.
`default_nettype none

package dcrs_pkg;

    localparam int CHANNELS_DEF = 512;

    // Action codes of an input beat
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Ramp length in ticks and the reciprocal used for the divide by three
    localparam logic [2:0]  RAMP_TICKS  = 3'd3;
    localparam logic [16:0] RECIP3      = 17'd43691;
    localparam int          RECIP_SHIFT = 17;

    // What one walk over the stores does to every channel
    typedef enum logic [1:0] {
        MODE_COPY,
        MODE_LOAD,
        MODE_ADD,
        MODE_SNAP
    } walk_mode_t;

    typedef struct packed {
        logic [7:0]  target;
        logic [15:0] smooth;
    } chan_word_t;

    typedef struct packed {
        logic       valid;
        walk_mode_t mode;
    } lane_ctl_t;

    typedef struct packed {
        logic        valid;
        logic        step_we;
        chan_word_t  word;
        logic [15:0] step;
    } lane_out_t;

    typedef struct packed {
        logic [15:0] level;
        logic        ramping;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/dmx_channel_ramp_smoother_core.sv
// Top level of the DMX channel ramp smoother: stores, update lane, sequencer, output register.
`default_nettype none

// Per-channel fader for CHANNELS DMX slots. Each input beat is one action:
// write stores a target byte, read returns the Q8.8 smoothed level, tick
// advances the fade. The first new frame after reset copies every target
// straight into the smoothed level; each later new frame loads a step of
// (target*256 - level)/3, truncated toward zero, and the frame's tick and
// the next two add it; the tick after that snaps every channel to its target.
// Every beat returns exactly one result beat; level is zero except on a read,
// and ramping is set while ramp or snap ticks remain. All state sits in two
// single-port-read memories (target with level, and step) with a registered
// read, so one beat is in flight at a time. A write turns around through a
// read, a modify and write, and a result. A tick that updates the channels
// walks both memories one channel per clock through a two-stage update lane.
// After reset the block clears every entry of the target and level memory
// with s_ready low. The result sits in an output register, so a stalled
// m_ready does not block the next input beat from being taken.
module dmx_channel_ramp_smoother_core #(
    parameter int CHANNELS = dcrs_pkg::CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [8:0]  s_channel,
    input  wire logic [7:0]  s_value,
    input  wire logic        s_new_frame,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_level,
    output logic             m_ramping
);
    import dcrs_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic          out_free;
    logic          res_valid;
    result_t       res;
    logic [AW-1:0] rd_addr;
    chan_word_t    rd_word;
    logic [15:0]   rd_step;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    chan_word_t    wr_word;
    lane_ctl_t     lane_ctl;
    lane_out_t     lane_out;

    logic        m_valid_reg;
    logic [15:0] m_level_reg;
    logic        m_ramping_reg;

    // Sequencer: owns the memory ports outside of the lane's write-back
    dcrs_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_channel   (s_channel),
        .s_value     (s_value),
        .s_new_frame (s_new_frame),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .rd_addr     (rd_addr),
        .rd_word     (rd_word),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_word     (wr_word),
        .lane_ctl    (lane_ctl),
        .lane_out    (lane_out)
    );

    // Target/level memory and step memory
    dcrs_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .aclk       (aclk),
        .rd_addr    (rd_addr),
        .rd_word    (rd_word),
        .rd_step    (rd_step),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_word    (wr_word),
        .step_wr_en (lane_out.step_we),
        .step_wdata (lane_out.step)
    );

    // Per-channel update lane, fed straight from the memory read data
    dcrs_lane u_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lane_ctl),
        .rd_word  (rd_word),
        .rd_step  (rd_step),
        .lane_out (lane_out)
    );

    // Output register: load a finished result once the slot is free, drop on take
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_level_reg   <= res.level;
            m_ramping_reg <= res.ramping;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_level   = m_level_reg;
    assign m_ramping = m_ramping_reg;

endmodule

`default_nettype wire

FILE: sv/dcrs_store.sv
// Channel and step memories, one write and one registered read port each.
`default_nettype none

module dcrs_store #(
    parameter int CHANNELS = dcrs_pkg::CHANNELS_DEF,
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                aclk,
    input  wire logic [AW-1:0]       rd_addr,
    output dcrs_pkg::chan_word_t     rd_word,
    output logic [15:0]              rd_step,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire dcrs_pkg::chan_word_t wr_word,
    input  wire logic                step_wr_en,
    input  wire logic [15:0]         step_wdata
);
    import dcrs_pkg::*;

    chan_word_t  chan_mem [CHANNELS];
    logic [15:0] step_mem [CHANNELS];

    chan_word_t  rd_word_reg;
    logic [15:0] rd_step_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            chan_mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= chan_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (step_wr_en) begin
            step_mem[wr_addr] <= step_wdata;
        end
        rd_step_reg <= step_mem[rd_addr];
    end

    assign rd_word = rd_word_reg;
    assign rd_step = rd_step_reg;

endmodule

`default_nettype wire

FILE: sv/dcrs_lane.sv
// Two-stage per-channel update: step by three, ramp add with clamp, copy and snap.
`default_nettype none

module dcrs_lane (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dcrs_pkg::lane_ctl_t  ctl,
    input  wire dcrs_pkg::chan_word_t rd_word,
    input  wire logic [15:0]          rd_step,
    output dcrs_pkg::lane_out_t       lane_out
);
    import dcrs_pkg::*;

    // Stage one: signed difference, its magnitude and the reciprocal product
    logic signed [17:0] diff;
    logic [17:0]        mag_full;
    logic [15:0]        mag;
    logic [32:0]        prod_next;

    logic        s1_vld_reg;
    walk_mode_t  s1_mode_reg;
    chan_word_t  s1_word_reg;
    logic [15:0] s1_step_reg;
    logic        s1_neg_reg;
    logic [32:0] s1_prod_reg;

    always_comb begin
        diff      = $signed({2'b00, rd_word.target, 8'h00}) - $signed({2'b00, rd_word.smooth});
        mag_full  = diff[17] ? 18'(-diff) : 18'(diff);
        mag       = mag_full[15:0];
        prod_next = 33'(mag) * 33'(RECIP3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        s1_mode_reg <= ctl.mode;
        s1_word_reg <= rd_word;
        s1_step_reg <= rd_step;
        s1_neg_reg  <= diff[17];
        s1_prod_reg <= prod_next;
    end

    // Stage two: sign the quotient, add, clamp, pick per mode
    logic [15:0]        quot;
    logic [15:0]        step_new;
    logic [15:0]        add_step;
    logic signed [17:0] sum;
    logic [15:0]        sat_val;
    logic [15:0]        t16;
    logic [15:0]        new_smooth;

    always_comb begin
        quot     = s1_prod_reg[RECIP_SHIFT +: 16];
        step_new = s1_neg_reg ? 16'(16'd0 - quot) : quot;
        add_step = (s1_mode_reg == MODE_LOAD) ? step_new : s1_step_reg;
        sum      = $signed({2'b00, s1_word_reg.smooth})
                 + $signed({{2{add_step[15]}}, add_step});
        if (sum[17]) begin
            sat_val = 16'h0000;
        end else if (sum[16]) begin
            sat_val = 16'hFFFF;
        end else begin
            sat_val = sum[15:0];
        end
        t16 = {s1_word_reg.target, 8'h00};
        case (s1_mode_reg) inside
            MODE_COPY, MODE_SNAP: new_smooth = t16;
            MODE_LOAD, MODE_ADD:  new_smooth = sat_val;
            default:              new_smooth = sat_val;
        endcase
        lane_out.valid       = s1_vld_reg;
        lane_out.step_we     = s1_vld_reg && (s1_mode_reg == MODE_LOAD);
        lane_out.word.target = s1_word_reg.target;
        lane_out.word.smooth = new_smooth;
        lane_out.step        = step_new;
    end

endmodule

`default_nettype wire

FILE: sv/dcrs_ctrl.sv
// Sequencer: clearing pass, read-modify-write of targets, level reads and tick walks.
`default_nettype none

module dcrs_ctrl #(
    parameter int CHANNELS = dcrs_pkg::CHANNELS_DEF,
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_action,
    input  wire logic [8:0]           s_channel,
    input  wire logic [7:0]           s_value,
    input  wire logic                 s_new_frame,
    input  wire logic                 out_free,
    output logic                      res_valid,
    output dcrs_pkg::result_t         res,
    output logic [AW-1:0]             rd_addr,
    input  wire dcrs_pkg::chan_word_t rd_word,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output dcrs_pkg::chan_word_t      wr_word,
    output dcrs_pkg::lane_ctl_t       lane_ctl,
    input  wire dcrs_pkg::lane_out_t  lane_out
);
    import dcrs_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RMW   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    walk_mode_t    mode_reg, mode_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    val_reg, val_next;
    logic [15:0]   level_reg, level_next;
    logic [2:0]    steps_left_reg, steps_left_next;
    logic          first_frame_reg, first_frame_next;
    logic          p1_vld_reg;
    logic [AW-1:0] p1_addr_reg;
    logic [AW-1:0] p2_addr_reg;

    logic chan_ok;

    always_comb begin
        chan_ok          = ({1'b0, s_channel} < 10'(CHANNELS));
        state_next       = state_reg;
        idx_next         = idx_reg;
        mode_next        = mode_reg;
        addr_next        = addr_reg;
        val_next         = val_reg;
        level_next       = level_reg;
        steps_left_next  = steps_left_reg;
        first_frame_next = first_frame_reg;
        rd_addr          = idx_reg;
        wr_en            = 1'b0;
        wr_addr          = p2_addr_reg;
        wr_word          = lane_out.word;
        res_valid        = 1'b0;
        s_ready          = (state_reg == ST_IDLE);

        if (lane_out.valid) begin
            wr_en = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_word = '0;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                rd_addr    = s_channel[AW-1:0];
                addr_next  = s_channel[AW-1:0];
                val_next   = s_value;
                level_next = '0;
                idx_next   = '0;
                if (s_valid) begin
                    unique case (s_action)
                        ACT_WRITE: begin
                            state_next = chan_ok ? ST_RMW : ST_DONE;
                        end
                        ACT_READ: begin
                            state_next = chan_ok ? ST_READ : ST_DONE;
                        end
                        ACT_TICK: begin
                            if (s_new_frame && first_frame_reg) begin
                                mode_next        = MODE_COPY;
                                first_frame_next = 1'b0;
                                state_next       = ST_WALK;
                            end else if (s_new_frame) begin
                                mode_next       = MODE_LOAD;
                                steps_left_next = RAMP_TICKS;
                                state_next      = ST_WALK;
                            end else if (steps_left_reg >= 3'd2) begin
                                mode_next       = MODE_ADD;
                                steps_left_next = steps_left_reg - 3'd1;
                                state_next      = ST_WALK;
                            end else if (steps_left_reg == 3'd1) begin
                                mode_next       = MODE_SNAP;
                                steps_left_next = 3'd0;
                                state_next      = ST_WALK;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                wr_en          = 1'b1;
                wr_addr        = addr_reg;
                wr_word.target = val_reg;
                wr_word.smooth = rd_word.smooth;
                state_next     = ST_DONE;
            end
            ST_READ: begin
                level_next = rd_word.smooth;
                state_next = ST_DONE;
            end
            ST_WALK: begin
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!p1_vld_reg && !lane_out.valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        lane_ctl.valid = p1_vld_reg;
        lane_ctl.mode  = mode_reg;
        res.level      = level_reg;
        res.ramping    = (steps_left_reg != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            idx_reg         <= '0;
            steps_left_reg  <= 3'd0;
            first_frame_reg <= 1'b1;
            p1_vld_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            steps_left_reg  <= steps_left_next;
            first_frame_reg <= first_frame_next;
            p1_vld_reg      <= (state_reg == ST_WALK);
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        addr_reg    <= addr_next;
        val_reg     <= val_next;
        level_reg   <= level_next;
        p1_addr_reg <= idx_reg;
        p2_addr_reg <= p1_addr_reg;
    end

endmodule

`default_nettype wire

FILE: sv/dcrs_checker.sv
// Port-level checks of the ramp smoother and their bind to the top level.
`default_nettype none

module dcrs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_level,
    input wire logic        m_ramping
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_ramping))
        else $error("result beat changed while stalled");

    // One beat in flight: an accepted input drops ready on the next clock
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // Reset starts the clearing pass with the input closed
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open right after reset");

    // No result beat is shown straight after reset
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

bind dmx_channel_ramp_smoother_core dcrs_checker u_dcrs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_level   (m_level),
    .m_ramping (m_ramping)
);

`default_nettype wire

FILE: tb/dmx_channel_ramp_smoother_core_tb.sv
// Self-checking testbench for the DMX channel ramp smoother core.
`timescale 1ns / 1ps

module dmx_channel_ramp_smoother_core_tb;
    import dcrs_pkg::*;

    localparam int         NUM_CHANNELS = CHANNELS_DEF;
    localparam logic [1:0] ACT_NONE     = 2'd3;     // unused action code, must be a no-op
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 600;      // one full channel walk plus margin
    localparam int         HOLD_AT      = 60;       // results seen before the long hold-off
    localparam int         HOLD_CYCLES  = 300;
    localparam int         PHASE_BEATS  = 285;
    localparam int         HOT_N        = 12;

    typedef struct packed {
        logic [1:0] action;
        logic [8:0] channel;
        logic [7:0] value;
        logic       new_frame;
    } fader_beat_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action    = ACT_WRITE;
    logic [8:0]  s_channel   = '0;
    logic [7:0]  s_value     = '0;
    logic        s_new_frame = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_level;
    logic        m_ramping;

    // Stimulus queue, expected results and handshake bookkeeping
    fader_beat_t pending_beats [$];
    result_t     due_results [$];
    int          beats_queued   = 0;
    int          beats_offered  = 0;
    int          beats_in       = 0;
    int          results_seen   = 0;
    int          err_cnt        = 0;
    int          cycle_cnt      = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    logic        hold_done      = 1'b0;
    logic [8:0]  hot_ch [HOT_N];

    // Shadow copy of the fader state
    logic [7:0]  target_mem [NUM_CHANNELS];
    logic [15:0] level_mem  [NUM_CHANNELS];
    logic [15:0] step_mem   [NUM_CHANNELS];
    int          ramp_left;
    logic        awaiting_first;

    dmx_channel_ramp_smoother_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_channel   (s_channel),
        .s_value     (s_value),
        .s_new_frame (s_new_frame),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_ramping   (m_ramping)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Apply one beat to the shadow state and return the result it must produce.
    function automatic result_t fader_predict(fader_beat_t b);
        result_t r;
        int      diff;
        int      sum;
        r.level = '0;
        case (b.action)
            ACT_WRITE: begin
                if (b.channel < NUM_CHANNELS) target_mem[b.channel] = b.value;
            end
            ACT_READ: begin
                if (b.channel < NUM_CHANNELS) r.level = level_mem[b.channel];
            end
            ACT_TICK: begin
                if (b.new_frame && awaiting_first) begin
                    // first frame: copy only, the ramp counter stays put
                    for (int i = 0; i < NUM_CHANNELS; i++) level_mem[i] = {target_mem[i], 8'h00};
                    awaiting_first = 1'b0;
                end else begin
                    if (b.new_frame) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            diff = int'({target_mem[i], 8'h00}) - int'(level_mem[i]);
                            step_mem[i] = 16'(diff / int'(RAMP_TICKS));
                        end
                        ramp_left = int'(RAMP_TICKS) + 1;
                    end
                    if (ramp_left >= 2) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            sum = int'(level_mem[i]) + int'($signed(step_mem[i]));
                            if (sum < 0) sum = 0;
                            if (sum > 65535) sum = 65535;
                            level_mem[i] = 16'(sum);
                        end
                        ramp_left--;
                    end else if (ramp_left == 1) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) level_mem[i] = {target_mem[i], 8'h00};
                        ramp_left = 0;
                    end
                end
            end
            default: ;
        endcase
        r.ramping = (ramp_left != 0);
        return r;
    endfunction

    task automatic queue_beat(logic [1:0] act, logic [8:0] ch, logic [7:0] val, logic nf);
        pending_beats.push_back('{act, ch, val, nf});
        beats_queued++;
    endtask

    // Mostly a small set of busy channels so reads see nonzero levels.
    function automatic logic [8:0] pick_channel();
        if ($urandom_range(3) == 0) return 9'($urandom_range(511));
        return hot_ch[$urandom_range(HOT_N - 1)];
    endfunction

    function automatic logic [7:0] pick_value();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One frame: targets and reads, the frame tick, then a few ramp ticks with
    // traffic between them. Occasionally drop the frame flag or restart a ramp.
    task automatic queue_frame_cycle();
        int n_ticks;
        repeat ($urandom_range(6))
            queue_beat(ACT_WRITE, pick_channel(), pick_value(), 1'($urandom_range(1)));
        repeat ($urandom_range(3))
            queue_beat(ACT_READ, pick_channel(), 8'($urandom), 1'($urandom_range(1)));
        if ($urandom_range(15) == 0)
            queue_beat(ACT_NONE, 9'($urandom), 8'($urandom), 1'($urandom_range(1)));
        queue_beat(ACT_TICK, 9'($urandom), 8'($urandom), $urandom_range(7) != 0);
        n_ticks = $urandom_range(5);
        repeat (n_ticks) begin
            repeat ($urandom_range(3)) begin
                if ($urandom_range(3) != 0)
                    queue_beat(ACT_READ, pick_channel(), 8'($urandom), 1'($urandom_range(1)));
                else
                    queue_beat(ACT_WRITE, pick_channel(), pick_value(), 1'($urandom_range(1)));
            end
            queue_beat(ACT_TICK, 9'($urandom), 8'($urandom), $urandom_range(9) == 0);
        end
    endtask

    // Input driver: present a beat at the falling edge, hold it until taken.
    always @(negedge aclk) begin : input_drive
        fader_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beats_in == beats_offered) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_beats.pop_front();
                s_action      <= nxt.action;
                s_channel     <= nxt.channel;
                s_value       <= nxt.value;
                s_new_frame   <= nxt.new_frame;
                s_valid       <= 1'b1;
                beats_offered <= beats_offered + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off to back the block up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check taken results first, then predict for a taken input beat.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                target_mem[i] = '0;
                level_mem[i]  = '0;
                step_mem[i]   = '0;
            end
            ramp_left      = 0;
            awaiting_first = 1'b1;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got level %04h ramping %0b",
                             $time, m_level, m_ramping);
                    err_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (m_level !== want.level) begin
                        $display("%0t: level mismatch, expected %04h, got %04h",
                                 $time, want.level, m_level);
                        err_cnt++;
                    end
                    if (m_ramping !== want.ramping) begin
                        $display("%0t: ramping mismatch, expected %0b, got %0b",
                                 $time, want.ramping, m_ramping);
                        err_cnt++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (s_valid && s_ready) begin
                due_results.push_back(fader_predict(
                    fader_beat_t'({s_action, s_channel, s_value, s_new_frame})));
                beats_in <= beats_in + 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        hot_ch[0] = 9'd0;
        hot_ch[1] = 9'd511;
        for (int i = 2; i < HOT_N; i++) hot_ch[i] = 9'($urandom_range(511));

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reads and an idle tick straight out of reset
        queue_beat(ACT_READ,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_READ,  9'd511, 8'hFF, 1'b1);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b0);
        // Extreme targets; frame flag on a write is ignored
        queue_beat(ACT_WRITE, 9'd0,   8'hFF, 1'b1);
        queue_beat(ACT_WRITE, 9'd511, 8'h00, 1'b0);
        queue_beat(ACT_WRITE, 9'd255, 8'hAA, 1'b0);
        queue_beat(ACT_WRITE, 9'd256, 8'h55, 1'b0);
        queue_beat(ACT_NONE,  9'd511, 8'hFF, 1'b1);
        queue_beat(ACT_READ,  9'd0,   8'h00, 1'b1);
        // First frame copies targets without a ramp
        queue_beat(ACT_TICK,  9'd511, 8'hFF, 1'b1);
        queue_beat(ACT_READ,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_READ,  9'd256, 8'h00, 1'b0);
        // Second frame: ramps down, up and by a sub-step amount
        queue_beat(ACT_WRITE, 9'd0,   8'h00, 1'b0);
        queue_beat(ACT_WRITE, 9'd511, 8'hFF, 1'b0);
        queue_beat(ACT_WRITE, 9'd255, 8'hA9, 1'b0);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b1);
        queue_beat(ACT_READ,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_READ,  9'd255, 8'h00, 1'b0);
        // Target change mid-ramp, then a frame that restarts the ramp
        queue_beat(ACT_WRITE, 9'd511, 8'h80, 1'b0);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b1);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_READ,  9'd511, 8'h00, 1'b0);
        // Snap tick, then idle again
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b0);
        queue_beat(ACT_READ,  9'd511, 8'h00, 1'b0);
        queue_beat(ACT_TICK,  9'd0,   8'h00, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            beats_queued = 0;
            while (beats_queued < PHASE_BEATS) queue_frame_cycle();
            // hold the sender until every result of this phase is back
            while (pending_beats.size() != 0 || s_valid || due_results.size() != 0)
                @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/dcrs_pkg.sv
sv/dcrs_store.sv
sv/dcrs_lane.sv
sv/dcrs_ctrl.sv
sv/dmx_channel_ramp_smoother_core.sv
sv/dcrs_checker.sv
tb/dmx_channel_ramp_smoother_core_tb.sv
